/* hdl/stb_pkg.sv */
// shared types and constants for the stun binding transaction block
// no dependencies; imported by every module
`default_nettype none

package stb_pkg;

    // request opcodes
    localparam logic [2:0] OP_START  = 3'd0;
    localparam logic [2:0] OP_LOOKUP = 3'd1;
    localparam logic [2:0] OP_TICK   = 3'd2;
    localparam logic [2:0] OP_RESP   = 3'd3;
    localparam logic [2:0] OP_CANCEL = 3'd4;

    // result event codes
    localparam logic [1:0] EV_SEND = 2'd0;
    localparam logic [1:0] EV_DONE = 2'd1;
    localparam logic [1:0] EV_FAIL = 2'd2;

    // register indexes
    localparam logic [1:0] REG_INIT_TIMEOUT = 2'd0;
    localparam logic [1:0] REG_TIMEOUT_CAP  = 2'd1;
    localparam logic [1:0] REG_RETX_LIMIT   = 2'd2;
    localparam logic [1:0] REG_INTEGRITY    = 2'd3;

    // register reset values
    localparam logic [15:0] INIT_TIMEOUT_RST = 16'd100;
    localparam logic [15:0] TIMEOUT_CAP_RST  = 16'd1600;
    localparam logic [3:0]  RETX_LIMIT_RST   = 4'd8;

    typedef enum logic [1:0] {
        PH_IDLE      = 2'd0,
        PH_RESOLVING = 2'd1,
        PH_WAITING   = 2'd2
    } t_phase;

    typedef struct packed {
        logic [15:0] initial_timeout_ticks;
        logic [15:0] timeout_cap_ticks;
        logic [3:0]  retransmit_limit;
        logic        integrity_enabled;
    } t_cfg;

    typedef struct packed {
        logic [2:0]  opcode;
        logic        lookup_ok;
        logic        resp_is_error;
        logic        has_integrity;
        logic        integrity_match;
        logic        has_xor_mapped;
        logic        has_mapped;
        logic [31:0] mapped_addr;
        logic [15:0] mapped_port;
        logic [31:0] xor_addr;
        logic [15:0] xor_port;
    } t_req;

    typedef struct packed {
        logic [1:0] event_res;
        logic       xor_only_flag;
        logic [3:0] attempt;
    } t_res;

endpackage

`default_nettype wire

/* hdl/stb_ifs.sv */
// valid/ready channel interfaces for requests and results
// depends on nothing; field names match the request and result structs of stb_pkg
`default_nettype none

interface stb_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  opcode;
    logic        lookup_ok;
    logic        resp_is_error;
    logic        has_integrity;
    logic        integrity_match;
    logic        has_xor_mapped;
    logic        has_mapped;
    logic [31:0] mapped_addr;
    logic [15:0] mapped_port;
    logic [31:0] xor_addr;
    logic [15:0] xor_port;

    modport source (
        output valid, opcode, lookup_ok, resp_is_error, has_integrity, integrity_match,
               has_xor_mapped, has_mapped, mapped_addr, mapped_port, xor_addr, xor_port,
        input  ready
    );
    modport sink (
        input  valid, opcode, lookup_ok, resp_is_error, has_integrity, integrity_match,
               has_xor_mapped, has_mapped, mapped_addr, mapped_port, xor_addr, xor_port,
        output ready
    );
endinterface

interface stb_res_if;
    logic       valid;
    logic       ready;
    logic [1:0] event_res;
    logic       xor_only_flag;
    logic [3:0] attempt;

    modport source (
        output valid, event_res, xor_only_flag, attempt,
        input  ready
    );
    modport sink (
        input  valid, event_res, xor_only_flag, attempt,
        output ready
    );
endinterface

`default_nettype wire

/* hdl/stun_binding_transaction.sv */
// top level of the stun binding transaction client
// depends on stb_pkg, stb_ifs, stb_cfg and stb_engine
//
//  channel   direction  handshake          carries
//  i_req     in         valid/ready        opcode, lookup, response attributes
//  o_res     out        valid/ready        event_res, xor_only_flag, attempt
//  apb       in         psel/penable       four config registers at 4*i
//
// one request per cycle unless a held result stalls the engine; a request is
// registered, evaluated combinationally and its result (if any) is written to the
// result register when the engine advances.
// a held result stalls the engine while o_res.ready is low; the request register
// takes a new request whenever it is empty or the engine can advance.
// synchronous active-low reset clears state and valids and sets config registers to their reset values.
`default_nettype none

module stun_binding_transaction
    import stb_pkg::*;
#(
    parameter int TIMER_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    stb_req_if.sink          i_req,
    stb_res_if.source        o_res,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    t_cfg cfg;
    t_req req;
    t_res res;
    logic req_ready;
    logic res_valid;

    assign req.opcode          = i_req.opcode;
    assign req.lookup_ok       = i_req.lookup_ok;
    assign req.resp_is_error   = i_req.resp_is_error;
    assign req.has_integrity   = i_req.has_integrity;
    assign req.integrity_match = i_req.integrity_match;
    assign req.has_xor_mapped  = i_req.has_xor_mapped;
    assign req.has_mapped      = i_req.has_mapped;
    assign req.mapped_addr     = i_req.mapped_addr;
    assign req.mapped_port     = i_req.mapped_port;
    assign req.xor_addr        = i_req.xor_addr;
    assign req.xor_port        = i_req.xor_port;
    assign i_req.ready         = req_ready;

    assign o_res.valid         = res_valid;
    assign o_res.event_res     = res.event_res;
    assign o_res.xor_only_flag = res.xor_only_flag;
    assign o_res.attempt       = res.attempt;

    stb_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    stb_engine #(
        .TIMER_BITS (TIMER_BITS)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_req_valid (i_req.valid),
        .o_req_ready (req_ready),
        .i_req       (req),
        .o_res_valid (res_valid),
        .i_res_ready (o_res.ready),
        .o_res       (res)
    );

endmodule

`default_nettype wire

/* hdl/stb_cfg.sv */
// apb-style configuration registers: timeouts, retransmit limit, integrity enable
// depends on stb_pkg
`default_nettype none

module stb_cfg
    import stb_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output t_cfg             o_cfg
);

    t_cfg       r_cfg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.initial_timeout_ticks <= INIT_TIMEOUT_RST;
            r_cfg.timeout_cap_ticks     <= TIMEOUT_CAP_RST;
            r_cfg.retransmit_limit      <= RETX_LIMIT_RST;
            r_cfg.integrity_enabled     <= 1'b0;
        end else if (wr_en) begin
            case (reg_idx)
                REG_INIT_TIMEOUT: r_cfg.initial_timeout_ticks <= pwdata[15:0];
                REG_TIMEOUT_CAP:  r_cfg.timeout_cap_ticks     <= pwdata[15:0];
                REG_RETX_LIMIT:   r_cfg.retransmit_limit      <= pwdata[3:0];
                REG_INTEGRITY:    r_cfg.integrity_enabled     <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_INIT_TIMEOUT: prdata = {16'd0, r_cfg.initial_timeout_ticks};
            REG_TIMEOUT_CAP:  prdata = {16'd0, r_cfg.timeout_cap_ticks};
            REG_RETX_LIMIT:   prdata = {28'd0, r_cfg.retransmit_limit};
            REG_INTEGRITY:    prdata = {31'd0, r_cfg.integrity_enabled};
            default:          prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

/* hdl/stb_engine.sv */
// transaction engine: request register, state update logic, result register
// depends on stb_pkg
`default_nettype none

module stb_engine
    import stb_pkg::*;
#(
    parameter int TIMER_BITS = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_cfg i_cfg,
    input  wire logic i_req_valid,
    output logic      o_req_ready,
    input  wire t_req i_req,
    output logic      o_res_valid,
    input  wire logic i_res_ready,
    output t_res      o_res
);

    // compare width wide enough for the doubled timer and the 16-bit cap
    localparam int WIDE = ((TIMER_BITS > 16) ? TIMER_BITS : 16) + 1;
    localparam logic [WIDE-1:0] TMAX = WIDE'((64'd1 << TIMER_BITS) - 64'd1);

    logic                  r_in_valid;
    t_req                  r_in;
    logic                  r_res_valid;
    t_res                  r_res;

    t_phase                r_phase,   n_phase;
    logic [3:0]            r_retries, n_retries;
    logic [TIMER_BITS-1:0] r_cur,     n_cur;
    logic [TIMER_BITS-1:0] r_ticks,   n_ticks;
    logic                  r_xo,      n_xo;

    logic                  adv;
    logic                  fire;
    logic                  emit;
    t_res                  n_res;
    logic                  do_arm;
    logic                  do_finish;
    logic [1:0]            fin_ev;
    logic                  busy;

    logic [WIDE-1:0]       init_w;
    logic [WIDE-1:0]       dbl_w;
    logic [WIDE-1:0]       cap_w;
    logic [WIDE-1:0]       dbl_cap;
    logic [TIMER_BITS-1:0] init_sat;
    logic [TIMER_BITS-1:0] dbl_sat;
    logic                  addr_diff;
    logic                  restart;
    logic                  drop;

    assign adv         = !r_res_valid || i_res_ready;
    assign o_req_ready = !r_in_valid || adv;
    assign fire        = r_in_valid && adv;
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;
    assign busy        = (r_phase == PH_RESOLVING) || (r_phase == PH_WAITING);

    // timeout arithmetic, saturated to the timer width
    assign init_w   = WIDE'(i_cfg.initial_timeout_ticks);
    assign init_sat = (init_w > TMAX) ? TMAX[TIMER_BITS-1:0] : init_w[TIMER_BITS-1:0];
    assign dbl_w    = WIDE'({r_cur, 1'b0});
    assign cap_w    = WIDE'(i_cfg.timeout_cap_ticks);
    assign dbl_cap  = (dbl_w > cap_w) ? cap_w : dbl_w;
    assign dbl_sat  = (dbl_cap > TMAX) ? TMAX[TIMER_BITS-1:0] : dbl_cap[TIMER_BITS-1:0];

    // response classification
    assign addr_diff = (r_in.mapped_addr != r_in.xor_addr)
                    || (r_in.mapped_port != r_in.xor_port);
    assign restart = !r_in.resp_is_error && r_in.has_integrity && !r_in.integrity_match
                  && !r_xo && r_in.has_xor_mapped && r_in.has_mapped && addr_diff;
    assign drop = !r_in.resp_is_error
               && ((r_in.has_integrity && !r_in.integrity_match && !restart)
                   || (!r_in.has_integrity && i_cfg.integrity_enabled));

    always_comb begin
        n_phase   = r_phase;
        n_retries = r_retries;
        n_cur     = r_cur;
        n_ticks   = r_ticks;
        n_xo      = r_xo;
        emit      = 1'b0;
        do_arm    = 1'b0;
        do_finish = 1'b0;
        fin_ev    = EV_FAIL;
        n_res     = '0;

        case (r_in.opcode)
            OP_START: begin
                if (!busy) begin
                    n_phase   = PH_RESOLVING;
                    n_retries = 4'd0;
                    n_cur     = '0;
                    n_ticks   = '0;
                    n_xo      = 1'b0;
                end
            end
            OP_LOOKUP: begin
                if (r_phase == PH_RESOLVING) begin
                    if (r_in.lookup_ok) begin
                        do_arm = 1'b1;
                    end else begin
                        do_finish = 1'b1;
                    end
                end
            end
            OP_TICK: begin
                if (r_phase == PH_WAITING) begin
                    if (r_ticks > TIMER_BITS'(1)) begin
                        n_ticks = r_ticks - TIMER_BITS'(1);
                    end else if (r_retries >= i_cfg.retransmit_limit) begin
                        do_finish = 1'b1;
                    end else begin
                        // retransmit with a doubled, capped timeout
                        n_retries       = r_retries + 4'd1;
                        n_cur           = dbl_sat;
                        n_ticks         = dbl_sat;
                        emit            = 1'b1;
                        n_res.event_res = EV_SEND;
                        n_res.attempt   = r_retries + 4'd1;
                    end
                end
            end
            OP_RESP: begin
                if (r_phase == PH_WAITING) begin
                    if (restart) begin
                        n_xo   = 1'b1;
                        do_arm = 1'b1;
                    end else if (!drop) begin
                        do_finish = 1'b1;
                        fin_ev    = EV_DONE;
                    end
                end
            end
            OP_CANCEL: begin
                if (busy) begin
                    do_finish = 1'b1;
                end
            end
            default: ;
        endcase

        if (do_arm) begin
            n_retries       = 4'd0;
            n_cur           = init_sat;
            n_ticks         = init_sat;
            n_phase         = PH_WAITING;
            emit            = 1'b1;
            n_res.event_res = EV_SEND;
            n_res.attempt   = 4'd0;
        end
        if (do_finish) begin
            n_phase         = PH_IDLE;
            n_ticks         = '0;
            emit            = 1'b1;
            n_res.event_res = fin_ev;
            n_res.attempt   = r_retries;
        end
        n_res.xor_only_flag = n_xo;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_res_valid <= 1'b0;
            r_phase     <= PH_IDLE;
            r_retries   <= 4'd0;
            r_cur       <= '0;
            r_ticks     <= '0;
            r_xo        <= 1'b0;
        end else begin
            if (o_req_ready) begin
                r_in_valid <= i_req_valid;
            end
            if (adv) begin
                r_res_valid <= r_in_valid && emit;
            end
            if (fire) begin
                r_phase   <= n_phase;
                r_retries <= n_retries;
                r_cur     <= n_cur;
                r_ticks   <= n_ticks;
                r_xo      <= n_xo;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req_valid && o_req_ready) begin
            r_in <= i_req;
        end
        if (adv) begin
            r_res <= n_res;
        end
    end

endmodule

`default_nettype wire
